// File: src/tbcr_pkg.sv
// ----------------------------------------------------------------------------
// tbcr_pkg
// shared constants and types for the blob centroid and radius block
// ----------------------------------------------------------------------------
package tbcr_pkg;

	localparam int PIX_W     = 8;
	localparam int COORD_W   = 12;
	localparam int COUNT_W   = 25;
	localparam int SUM_W     = 37;
	localparam int THR_W     = 8;
	localparam int FW_W      = 13;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int GRAY_W    = 22;
	localparam int GRAY_FRAC = 14;

	// long division datapath: dividend/quotient shift register and divisor
	localparam int DIV_W     = 55;
	localparam int DVS_W     = 32;
	localparam int PI_SHIFT  = 30;
	localparam int ROOT_W    = 12;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int SREM_W    = ROOT_W + 1;
	localparam int STEP_W    = 6;

	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

	localparam logic [10:0]       COEF_B    = 11'd1868;
	localparam logic [13:0]       COEF_G    = 14'd9617;
	localparam logic [12:0]       COEF_R    = 13'd4899;
	localparam logic [GRAY_W-1:0] GRAY_RND  = GRAY_W'(8192);
	localparam logic [DVS_W-1:0]  PI_Q30    = 32'd3373259426;

	localparam logic [FW_W-1:0]    MAX_WIDTH = FW_W'(4096);
	localparam logic [COORD_W-1:0] ROW_LAST  = COORD_W'(4095);
	localparam logic [COUNT_W-1:0] WHITE_CAP = COUNT_W'(4096 * 4096);

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);
	localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(1024);

	localparam logic REG_THR = 1'b0;
	localparam logic REG_FW  = 1'b1;

	typedef struct packed {
		logic               start;
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   csum;
		logic [SUM_W-1:0]   rsum;
	} sol_req_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [ROOT_W-1:0]  radius;
		logic [COUNT_W-1:0] count;
		logic               empty;
	} sol_res_t;

endpackage

// File: src/tbcr_if.sv
// ----------------------------------------------------------------------------
// tbcr_if
// valid/ready channels for pixel words and frame result words
// ----------------------------------------------------------------------------
interface tbcr_pix_if;
	logic                       valid;
	logic                       ready;
	logic [tbcr_pkg::PIX_W-1:0] pixel_blue;
	logic [tbcr_pkg::PIX_W-1:0] pixel_green;
	logic [tbcr_pkg::PIX_W-1:0] pixel_red;
	logic                       frame_end;

	modport source (output valid, pixel_blue, pixel_green, pixel_red, frame_end,
		input ready);
	modport sink (input valid, pixel_blue, pixel_green, pixel_red, frame_end,
		output ready);
endinterface

interface tbcr_res_if;
	logic                         valid;
	logic                         ready;
	logic [tbcr_pkg::COORD_W-1:0] center_x;
	logic [tbcr_pkg::COORD_W-1:0] center_y;
	logic [tbcr_pkg::ROOT_W-1:0]  circle_radius;
	logic [tbcr_pkg::COUNT_W-1:0] white_count;
	logic                         empty_frame;

	modport source (output valid, center_x, center_y, circle_radius, white_count,
		empty_frame, input ready);
	modport sink (input valid, center_x, center_y, circle_radius, white_count,
		empty_frame, output ready);
endinterface

// File: src/threshold_blob_centroid_radius.sv
// ----------------------------------------------------------------------------
// threshold_blob_centroid_radius
// centroid and equal-area radius of the bright region of a bgr frame
// ----------------------------------------------------------------------------
// pix carries one bgr pixel word per cycle in raster order; frame_end marks
// the last pixel of a frame. res carries one result word per frame: centroid,
// radius, white pixel count and an empty flag (all other fields zero when set).
// the apb port holds the gray threshold (0x0) and the row width (0x4).
// pixels are taken back to back, one per cycle, inside a frame. once the
// frame_end word is taken, pix.ready stays low until the frame result sits in
// the output register: the capture and threshold stages, then the bit-serial
// solver runs three 55-step long divisions (x, y, count/pi) and a 12-step
// square root, one bit per cycle; for an empty frame the solver skips the
// divisions and the root.
// the output register holds a result while res.ready is low; the next frame
// streams in meanwhile, and only its own result waits for the register.
// reset clears the counters, sums and valids and loads threshold 128 and
// width 1024.
// ----------------------------------------------------------------------------
module threshold_blob_centroid_radius (
	input  logic                          clk,
	input  logic                          arst_n,
	tbcr_pix_if.sink                      pix,
	tbcr_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbcr_pkg::ADDR_W-1:0]   paddr,
	input  logic [tbcr_pkg::DATA_W-1:0]   pwdata,
	output logic [tbcr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [tbcr_pkg::THR_W-1:0]   thr_q;
	logic [tbcr_pkg::FW_W-1:0]    fw_q;
	logic                         busy_q;
	logic [tbcr_pkg::COORD_W-1:0] col_q;
	logic [tbcr_pkg::COORD_W-1:0] row_q;

	logic                         val_s1;
	logic [tbcr_pkg::PIX_W-1:0]   b_s1;
	logic [tbcr_pkg::PIX_W-1:0]   g_s1;
	logic [tbcr_pkg::PIX_W-1:0]   r_s1;
	logic                         last_s1;
	logic [tbcr_pkg::COORD_W-1:0] col_s1;
	logic [tbcr_pkg::COORD_W-1:0] row_s1;

	logic                         val_s2;
	logic                         white_s2;
	logic                         last_s2;
	logic [tbcr_pkg::COORD_W-1:0] col_s2;
	logic [tbcr_pkg::COORD_W-1:0] row_s2;

	logic [tbcr_pkg::COUNT_W-1:0] tot_q;
	logic [tbcr_pkg::SUM_W-1:0]   csum_q;
	logic [tbcr_pkg::SUM_W-1:0]   rsum_q;

	logic                         res_valid_q;
	logic [tbcr_pkg::COORD_W-1:0] res_cx_q;
	logic [tbcr_pkg::COORD_W-1:0] res_cy_q;
	logic [tbcr_pkg::ROOT_W-1:0]  res_rad_q;
	logic [tbcr_pkg::COUNT_W-1:0] res_cnt_q;
	logic                         res_empty_q;

	logic                         cfg_wr;
	logic                         pix_acc;
	logic [tbcr_pkg::FW_W-1:0]    fw_eff;
	logic                         col_wrap;
	logic [tbcr_pkg::GRAY_W-1:0]  gray_sum;
	logic                         add;
	logic [tbcr_pkg::COUNT_W-1:0] tot_nx;
	logic [tbcr_pkg::SUM_W-1:0]   csum_nx;
	logic [tbcr_pkg::SUM_W-1:0]   rsum_nx;
	logic                         ack;
	tbcr_pkg::sol_req_t           sreq;
	tbcr_pkg::sol_res_t           sres;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tbcr_pkg::THR_RESET;
			fw_q  <= tbcr_pkg::FW_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				tbcr_pkg::REG_THR: thr_q <= pwdata[tbcr_pkg::THR_W-1:0];
				tbcr_pkg::REG_FW:  fw_q  <= pwdata[tbcr_pkg::FW_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tbcr_pkg::REG_THR: prdata = tbcr_pkg::DATA_W'(thr_q);
			tbcr_pkg::REG_FW:  prdata = tbcr_pkg::DATA_W'(fw_q);
		endcase
	end

	// pixel coordinates, advanced per accepted word
	assign pix.ready = !busy_q;
	assign pix_acc   = pix.valid && !busy_q;
	assign fw_eff    = (fw_q == '0 || fw_q > tbcr_pkg::MAX_WIDTH) ? tbcr_pkg::MAX_WIDTH : fw_q;
	assign col_wrap  = (tbcr_pkg::FW_W'(col_q) + tbcr_pkg::FW_W'(1)) >= fw_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (pix_acc) begin
				if (pix.frame_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_wrap) begin
					col_q <= '0;
					row_q <= (row_q == tbcr_pkg::ROW_LAST) ? '0 :
						row_q + tbcr_pkg::COORD_W'(1);
				end else begin
					col_q <= col_q + tbcr_pkg::COORD_W'(1);
				end
			end
			if (pix_acc && pix.frame_end) begin
				busy_q <= 1'b1;
			end else if (ack) begin
				busy_q <= 1'b0;
			end
		end
	end

	// stage 1: capture the pixel; stage 2: gray level against threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
		end else begin
			val_s1 <= pix_acc;
			val_s2 <= val_s1;
		end
	end

	assign gray_sum = tbcr_pkg::GRAY_W'(b_s1) * tbcr_pkg::GRAY_W'(tbcr_pkg::COEF_B)
		+ tbcr_pkg::GRAY_W'(g_s1) * tbcr_pkg::GRAY_W'(tbcr_pkg::COEF_G)
		+ tbcr_pkg::GRAY_W'(r_s1) * tbcr_pkg::GRAY_W'(tbcr_pkg::COEF_R)
		+ tbcr_pkg::GRAY_RND;

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			b_s1    <= pix.pixel_blue;
			g_s1    <= pix.pixel_green;
			r_s1    <= pix.pixel_red;
			last_s1 <= pix.frame_end;
			col_s1  <= col_q;
			row_s1  <= row_q;
		end
		white_s2 <= gray_sum[tbcr_pkg::GRAY_FRAC +: tbcr_pkg::PIX_W] > thr_q;
		last_s2  <= last_s1;
		col_s2   <= col_s1;
		row_s2   <= row_s1;
	end

	// moment accumulators, frozen once the count reaches the cap
	always_comb begin
		add     = val_s2 && white_s2 && (tot_q < tbcr_pkg::WHITE_CAP);
		tot_nx  = tot_q + tbcr_pkg::COUNT_W'(add);
		csum_nx = csum_q + (add ? tbcr_pkg::SUM_W'(col_s2) : '0);
		rsum_nx = rsum_q + (add ? tbcr_pkg::SUM_W'(row_s2) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q  <= '0;
			csum_q <= '0;
			rsum_q <= '0;
		end else if (val_s2) begin
			if (last_s2) begin
				tot_q  <= '0;
				csum_q <= '0;
				rsum_q <= '0;
			end else begin
				tot_q  <= tot_nx;
				csum_q <= csum_nx;
				rsum_q <= rsum_nx;
			end
		end
	end

	assign sreq.start = val_s2 && last_s2;
	assign sreq.count = tot_nx;
	assign sreq.csum  = csum_nx;
	assign sreq.rsum  = rsum_nx;

	tbcr_solve u_solve (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.ack    (ack),
		.res    (sres)
	);

	// output register
	assign ack = sres.done && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ack) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			res_cx_q    <= sres.center_x;
			res_cy_q    <= sres.center_y;
			res_rad_q   <= sres.radius;
			res_cnt_q   <= sres.count;
			res_empty_q <= sres.empty;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.center_x      = res_cx_q;
	assign res.center_y      = res_cy_q;
	assign res.circle_radius = res_rad_q;
	assign res.white_count   = res_cnt_q;
	assign res.empty_frame   = res_empty_q;

endmodule

// File: src/tbcr_solve.sv
// ----------------------------------------------------------------------------
// tbcr_solve
// bit-serial centroid division and equal-area radius at frame end
// ----------------------------------------------------------------------------
module tbcr_solve (
	input  logic               clk,
	input  logic               arst_n,
	input  tbcr_pkg::sol_req_t req,
	input  logic               ack,
	output tbcr_pkg::sol_res_t res
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIVX = 6'b000010,
		ST_DIVY = 6'b000100,
		ST_DIVP = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t                               state_q;
	logic [tbcr_pkg::STEP_W-1:0]          step_q;
	logic [tbcr_pkg::COUNT_W-1:0]         cnt_q;
	logic [tbcr_pkg::SUM_W-1:0]           rsum_q;
	logic [tbcr_pkg::DIV_W-1:0]           a_q;
	logic [tbcr_pkg::DVS_W-1:0]           rem_q;
	logic [tbcr_pkg::COORD_W-1:0]         cx_q;
	logic [tbcr_pkg::COORD_W-1:0]         cy_q;
	logic [tbcr_pkg::ROOT_W-1:0]          root_q;
	logic [tbcr_pkg::RAD_W-1:0]           sq_d_q;
	logic [tbcr_pkg::SREM_W-1:0]          sq_rem_q;
	logic                                 empty_q;

	logic [tbcr_pkg::DVS_W-1:0]           divisor;
	logic [tbcr_pkg::DVS_W:0]             rem_t;
	logic                                 dge;
	logic [tbcr_pkg::DVS_W:0]             rem_d;
	logic [tbcr_pkg::DVS_W-1:0]           rem_n;
	logic [tbcr_pkg::DIV_W-1:0]           a_n;
	logic [tbcr_pkg::SREM_W+1:0]          sr_t;
	logic [tbcr_pkg::SREM_W:0]            trial;
	logic                                 sge;
	logic [tbcr_pkg::SREM_W+1:0]          sr_d;
	logic [tbcr_pkg::STEP_W-1:0]          step_n;

	// one quotient bit per cycle: shift in a dividend bit, try the subtract
	always_comb begin
		divisor = (state_q == ST_DIVP) ? tbcr_pkg::PI_Q30 : tbcr_pkg::DVS_W'(cnt_q);
		rem_t   = {rem_q, a_q[tbcr_pkg::DIV_W-1]};
		dge     = rem_t >= {1'b0, divisor};
		rem_d   = rem_t - {1'b0, divisor};
		rem_n   = dge ? rem_d[tbcr_pkg::DVS_W-1:0] : rem_t[tbcr_pkg::DVS_W-1:0];
		a_n     = {a_q[tbcr_pkg::DIV_W-2:0], dge};
		step_n  = step_q + tbcr_pkg::STEP_W'(1);
	end

	// one root bit per cycle from two radicand bits
	always_comb begin
		sr_t  = {sq_rem_q, sq_d_q[tbcr_pkg::RAD_W-1 -: 2]};
		trial = {root_q, 2'b01};
		sge   = sr_t >= {1'b0, trial};
		sr_d  = sr_t - {1'b0, trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						step_q <= '0;
						if (req.count == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIVX;
						end
					end
				end
				ST_DIVX, ST_DIVY, ST_DIVP: begin
					if (step_q == tbcr_pkg::DIV_LAST) begin
						step_q  <= '0;
						state_q <= (state_q == ST_DIVX) ? ST_DIVY :
							(state_q == ST_DIVY) ? ST_DIVP : ST_SQRT;
					end else begin
						step_q <= step_n;
					end
				end
				ST_SQRT: begin
					if (step_q == tbcr_pkg::SQRT_LAST) begin
						step_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						step_q <= step_n;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					cnt_q    <= req.count;
					rsum_q   <= req.rsum;
					a_q      <= tbcr_pkg::DIV_W'(req.csum);
					rem_q    <= '0;
					cx_q     <= '0;
					cy_q     <= '0;
					root_q   <= '0;
					empty_q  <= (req.count == '0);
				end
			end
			ST_DIVX: begin
				if (step_q == tbcr_pkg::DIV_LAST) begin
					cx_q  <= a_n[tbcr_pkg::COORD_W-1:0];
					a_q   <= tbcr_pkg::DIV_W'(rsum_q);
					rem_q <= '0;
				end else begin
					a_q   <= a_n;
					rem_q <= rem_n;
				end
			end
			ST_DIVY: begin
				if (step_q == tbcr_pkg::DIV_LAST) begin
					cy_q  <= a_n[tbcr_pkg::COORD_W-1:0];
					a_q   <= {cnt_q, {tbcr_pkg::PI_SHIFT{1'b0}}};
					rem_q <= '0;
				end else begin
					a_q   <= a_n;
					rem_q <= rem_n;
				end
			end
			ST_DIVP: begin
				if (step_q == tbcr_pkg::DIV_LAST) begin
					// r*r <= count/pi holds exactly when r*r <= its floor
					sq_d_q   <= {1'b0, a_n[tbcr_pkg::RAD_W-2:0]};
					sq_rem_q <= '0;
					root_q   <= '0;
				end else begin
					a_q   <= a_n;
					rem_q <= rem_n;
				end
			end
			ST_SQRT: begin
				sq_d_q   <= {sq_d_q[tbcr_pkg::RAD_W-3:0], 2'b00};
				sq_rem_q <= sge ? sr_d[tbcr_pkg::SREM_W-1:0] : sr_t[tbcr_pkg::SREM_W-1:0];
				root_q   <= {root_q[tbcr_pkg::ROOT_W-2:0], sge};
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign res.done     = (state_q == ST_DONE);
	assign res.center_x = cx_q;
	assign res.center_y = cy_q;
	assign res.radius   = root_q;
	assign res.count    = cnt_q;
	assign res.empty    = empty_q;

endmodule

// File: src/tbcr_chk.sv
// ----------------------------------------------------------------------------
// tbcr_chk
// port-level checks on the blob centroid and radius block
// ----------------------------------------------------------------------------
module tbcr_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pix_valid,
	input logic                         pix_ready,
	input logic                         pix_end,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [tbcr_pkg::COORD_W-1:0] center_x,
	input logic [tbcr_pkg::COORD_W-1:0] center_y,
	input logic [tbcr_pkg::ROOT_W-1:0]  circle_radius,
	input logic [tbcr_pkg::COUNT_W-1:0] white_count,
	input logic                         empty_frame
);

	// a stalled result word holds its valid, white count, center_x and empty flag
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(white_count)
			&& $stable(center_x) && $stable(empty_frame))
		else $error("result word changed while stalled");

	// an empty frame reports all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_frame |-> center_x == '0 && center_y == '0
			&& circle_radius == '0 && white_count == '0)
		else $error("empty frame with nonzero fields");

	// a non-empty frame has a count and a radius in range
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !empty_frame |-> white_count != '0
			&& circle_radius <= tbcr_pkg::ROOT_W'(2400))
		else $error("non-empty frame with bad count or radius");

	// a taken frame end word closes the input
	a_end_block: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix_end |=> !pix_ready)
		else $error("input open right after frame end");

endmodule

bind threshold_blob_centroid_radius tbcr_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.pix_end       (pix.frame_end),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.center_x      (res.center_x),
	.center_y      (res.center_y),
	.circle_radius (res.circle_radius),
	.white_count   (res.white_count),
	.empty_frame   (res.empty_frame)
);
